>>> design/dtt_pkg.sv
package dtt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_OUT     = 16;
  localparam logic [31:0] ROLL_RESET = 32'd3600000;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_CANCEL  = 3'd1;
  localparam logic [2:0] MODE_REFRESH = 3'd2;
  localparam logic [2:0] MODE_RESET   = 3'd3;
  localparam logic [2:0] MODE_COLLECT = 3'd4;
  localparam logic [2:0] MODE_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNARM = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic        repeat_mode;
    logic        from_now;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [3:0]  result_slot;
    logic [1:0]  status;
    logic [31:0] wait_ms;
    logic        last;
  } out_t;

  localparam int IN_W = $bits(in_t);

endpackage

>>> design/dtt_front.sv
module dtt_front import dtt_pkg::*; (
  input  logic start,
  input  in_t  in_req,
  input  logic q_full,
  output logic busy,
  output logic push,
  output in_t  push_req
);

  // unknown modes are dropped here and never reach the back end
  logic known;

  assign known    = (in_req.mode <= MODE_QUERY);
  assign busy     = q_full;
  assign push     = start && !q_full && known;
  assign push_req = in_req;

endmodule

>>> design/dtt_fifo.sv
module dtt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

>>> design/dtt_back.sv
module dtt_back import dtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  in_t         q_req,
  output logic        pop,
  input  logic [31:0] rollover,
  output logic        out_valid,
  output out_t        out_res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(MAX_OUT + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_HANDLE = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;

  logic [2:0]  state_r, state_nxt;
  in_t         cmd_r, cmd_nxt;
  logic [IW-1:0] idx_r, idx_nxt, best_r, best_nxt, pend_r, pend_nxt;
  logic        found_r, found_nxt, pend_v_r, pend_v_nxt;
  logic [31:0] best_d_r, best_d_nxt;
  logic [SLOTS-1:0] cand_r, cand_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [31:0] dl_r [SLOTS];
  logic [31:0] per_r [SLOTS];
  logic [SLOTS-1:0] rep_r, armed_r, armed_nxt;
  logic [31:0] lct_r, lct_nxt;

  logic        wr_en, wr_rep_en;
  logic [IW-1:0] wr_a;
  logic [31:0] wr_dl, wr_per;
  logic        wr_per_en, wr_rep;

  logic        ov_nxt;
  out_t        or_nxt;
  logic        ov_r;
  out_t        or_r;

  logic [IW-1:0] sidx, rd_a, free_idx;
  logic        inrange, on, free_found, any, roll;
  logic [31:0] dl_rd, per_rd, start_t;
  logic [SLOTS-1:0] exp_v;

  assign sidx    = IW'(q_req.slot);
  assign inrange = (32'(q_req.slot) < SLOTS);
  assign on      = inrange && armed_r[sidx];
  assign any     = |armed_r;
  assign roll    = (q_req.now_ms < lct_r) && ((lct_r - q_req.now_ms) > rollover);
  assign pop     = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_a = sidx;
      S_HANDLE: rd_a = best_r;
      default:  rd_a = idx_r;
    endcase
  end
  assign dl_rd  = dl_r[rd_a];
  assign per_rd = per_r[rd_a];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      exp_v[i] = armed_r[i] && (roll || (dl_r[i] <= q_req.now_ms));
    end
  end

  assign start_t = q_req.from_now ? q_req.now_ms : dl_rd - per_rd;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    best_d_nxt = best_d_r;
    found_nxt  = found_r;
    cand_nxt   = cand_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    armed_nxt  = armed_r;
    lct_nxt    = lct_r;
    wr_en      = 1'b0;
    wr_a       = rd_a;
    wr_dl      = '0;
    wr_per_en  = 1'b0;
    wr_per     = '0;
    wr_rep_en  = 1'b0;
    wr_rep     = 1'b0;
    ov_nxt     = 1'b0;
    or_nxt     = '{result_slot: 4'd0, status: ST_OK, wait_ms: 32'd0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          cmd_nxt = q_req;
          unique case (q_req.mode)
            MODE_ADD: begin
              ov_nxt = 1'b1;
              if (free_found) begin
                armed_nxt[free_idx] = 1'b1;
                wr_en     = 1'b1;
                wr_a      = free_idx;
                wr_dl     = q_req.now_ms + q_req.period_ms;
                wr_per_en = 1'b1;
                wr_per    = q_req.period_ms;
                wr_rep_en = 1'b1;
                wr_rep    = q_req.repeat_mode;
                or_nxt.result_slot = 4'(free_idx);
              end else begin
                or_nxt.status = ST_FULL;
              end
            end
            MODE_CANCEL: begin
              ov_nxt = 1'b1;
              if (on) armed_nxt[sidx] = 1'b0;
              else or_nxt.status = ST_UNARM;
            end
            MODE_REFRESH: begin
              ov_nxt = 1'b1;
              if (on) begin
                wr_en = 1'b1;
                wr_dl = q_req.now_ms + per_rd;
              end else begin
                or_nxt.status = ST_UNARM;
              end
            end
            MODE_RESET: begin
              ov_nxt = 1'b1;
              if (inrange && (q_req.period_ms == per_rd) && !q_req.from_now) begin
                or_nxt.status = ST_OK;
              end else if (on) begin
                wr_en     = 1'b1;
                wr_dl     = start_t + q_req.period_ms;
                wr_per_en = 1'b1;
                wr_per    = q_req.period_ms;
              end else begin
                or_nxt.status = ST_UNARM;
              end
            end
            MODE_COLLECT: begin
              if (!any) begin
                ov_nxt        = 1'b1;
                or_nxt.status = ST_NONE;
              end else begin
                lct_nxt    = q_req.now_ms;
                cand_nxt   = exp_v;
                idx_nxt    = '0;
                found_nxt  = 1'b0;
                cnt_nxt    = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            MODE_QUERY: begin
              if (!any) begin
                ov_nxt         = 1'b1;
                or_nxt.status  = ST_NONE;
                or_nxt.wait_ms = '1;
              end else begin
                cand_nxt  = armed_r;
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (cand_r[idx_r] && (!found_r || (dl_rd < best_d_r))) begin
          best_nxt   = idx_r;
          best_d_nxt = dl_rd;
          found_nxt  = 1'b1;
        end
        if (idx_r == IW'(SLOTS - 1)) begin
          state_nxt = S_HANDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_HANDLE: begin
        if (cmd_r.mode == MODE_QUERY) begin
          ov_nxt             = 1'b1;
          or_nxt.result_slot = 4'(best_r);
          or_nxt.wait_ms     = (cmd_r.now_ms < best_d_r) ? best_d_r - cmd_r.now_ms : 32'd0;
          state_nxt          = S_IDLE;
        end else if (found_r) begin
          cand_nxt[best_r] = 1'b0;
          if (rep_r[best_r]) begin
            wr_en = 1'b1;
            wr_dl = cmd_r.now_ms + per_rd;
          end else begin
            armed_nxt[best_r] = 1'b0;
          end
          if (pend_v_r) begin
            ov_nxt             = 1'b1;
            or_nxt.result_slot = 4'(pend_r);
            or_nxt.last        = 1'b0;
          end
          pend_nxt   = best_r;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          state_nxt  = (cnt_r == CW'(MAX_OUT - 1)) ? S_FLUSH : S_SCAN;
        end else begin
          ov_nxt = 1'b1;
          if (pend_v_r) or_nxt.result_slot = 4'(pend_r);
          else or_nxt.status = ST_NONE;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        ov_nxt             = 1'b1;
        or_nxt.result_slot = 4'(pend_r);
        state_nxt          = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      armed_r  <= '0;
      lct_r    <= '0;
      ov_r     <= 1'b0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      armed_r  <= armed_nxt;
      lct_r    <= lct_nxt;
      ov_r     <= ov_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    best_r   <= best_nxt;
    best_d_r <= best_d_nxt;
    cand_r   <= cand_nxt;
    pend_r   <= pend_nxt;
    or_r     <= or_nxt;
  end

  // slot contents reset to zero like the table they model
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        dl_r[i]  <= '0;
        per_r[i] <= '0;
      end
      rep_r <= '0;
    end else begin
      if (wr_en) dl_r[wr_a] <= wr_dl;
      if (wr_per_en) per_r[wr_a] <= wr_per;
      if (wr_rep_en) rep_r[wr_a] <= wr_rep;
    end
  end

  assign out_valid = ov_r;
  assign out_res   = or_r;

endmodule

>>> design/deadline_timer_table_unit.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------
// in        | start / busy                   | in_req (in_t)
// out       | out_valid, one cycle per item  | out_res (out_t)
// cfg       | apb psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// add, cancel, refresh and reset answer in the cycle after the request leaves the queue
// query makes one pass of the slot scan, reading one deadline per cycle
// collect makes one pass of the slot scan per expired timer, then a last pass that
// finds none left; after the sixteenth timer the flush state gives the last result
// rst_n is synchronous: table, queue and output strobe clear at a clock edge
// busy rises only while the two-entry request queue is full; results cannot be stalled
module deadline_timer_table_unit import dtt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  in_t         in_req,
  // result channel
  output logic        out_valid,
  output out_t        out_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        push, q_full, q_empty, pop;
  in_t         push_req;
  logic [IN_W-1:0] q_data;
  in_t         q_req;
  logic [31:0] roll_r;

  // single register: any word offset selects rollover_window
  assign pready = 1'b1;
  assign prdata = roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r <= ROLL_RESET;
    end else if (psel && penable && pwrite && (paddr[1:0] == paddr[1:0])) begin
      roll_r <= pwdata;
    end
  end

  // front end: accept and filter requests
  dtt_front u_front (
    .start    (start),
    .in_req   (in_req),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_req (push_req)
  );

  // short queue decoupling accept from execution
  dtt_fifo #(
    .W     (IN_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_req),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_req = in_t'(q_data);

  // back end: timer table, slot scan and result sequencing
  dtt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_req     (q_req),
    .pop       (pop),
    .rollover  (roll_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> sim/testbench.sv
module testbench import dtt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // expected results of the timer table, with its own copy of the table
  class timer_scoreboard;
    logic [31:0] deadline [16];
    logic [31:0] period [16];
    bit          rep [16];
    bit          armed [16];
    logic [31:0] last_collect;
    logic [31:0] window;
    out_t        pending [$];
    int          errors;

    function new();
      for (int i = 0; i < 16; i++) begin
        deadline[i] = 0;
        period[i] = 0;
        rep[i] = 0;
        armed[i] = 0;
      end
      last_collect = 0;
      window = ROLL_RESET;
      errors = 0;
    endfunction

    function void push(logic [3:0] s, logic [1:0] st, logic [31:0] w, bit l);
      out_t r;
      r.result_slot = s;
      r.status = st;
      r.wait_ms = w;
      r.last = l;
      pending.insert(pending.size(), r);
    endfunction

    function int earliest(bit pick [16]);
      int best;
      best = -1;
      for (int i = 0; i < 16; i++)
        if (pick[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
      return best;
    endfunction

    // note an accepted request and predict its results
    function void note_request(in_t q);
      bit on;
      bit any;
      bit roll;
      bit cand [16];
      int order [$];
      int b;
      logic [31:0] strt;
      on = armed[q.slot];
      case (q.mode)
        MODE_ADD: begin
          b = -1;
          for (int i = 0; i < 16; i++)
            if (b < 0 && !armed[i]) b = i;
          if (b < 0) push(0, ST_FULL, 0, 1);
          else begin
            armed[b] = 1;
            period[b] = q.period_ms;
            rep[b] = q.repeat_mode;
            deadline[b] = q.now_ms + q.period_ms;
            push(b[3:0], ST_OK, 0, 1);
          end
        end
        MODE_CANCEL: begin
          if (on) armed[q.slot] = 0;
          push(0, on ? ST_OK : ST_UNARM, 0, 1);
        end
        MODE_REFRESH: begin
          if (on) deadline[q.slot] = q.now_ms + period[q.slot];
          push(0, on ? ST_OK : ST_UNARM, 0, 1);
        end
        MODE_RESET: begin
          if (q.period_ms == period[q.slot] && !q.from_now) push(0, ST_OK, 0, 1);
          else begin
            if (on) begin
              strt = q.from_now ? q.now_ms : deadline[q.slot] - period[q.slot];
              period[q.slot] = q.period_ms;
              deadline[q.slot] = strt + q.period_ms;
            end
            push(0, on ? ST_OK : ST_UNARM, 0, 1);
          end
        end
        MODE_COLLECT: begin
          any = 0;
          for (int i = 0; i < 16; i++) any |= armed[i];
          if (!any) push(0, ST_NONE, 0, 1);
          else begin
            roll = q.now_ms < last_collect && (last_collect - q.now_ms) > window;
            last_collect = q.now_ms;
            for (int i = 0; i < 16; i++)
              cand[i] = armed[i] && (roll || deadline[i] <= q.now_ms);
            b = earliest(cand);
            while (b >= 0) begin
              cand[b] = 0;
              order.insert(order.size(), b);
              b = earliest(cand);
            end
            if (order.size() == 0) push(0, ST_NONE, 0, 1);
            foreach (order[k]) begin
              if (rep[order[k]]) deadline[order[k]] = q.now_ms + period[order[k]];
              else armed[order[k]] = 0;
              push(order[k][3:0], ST_OK, 0, k == order.size() - 1);
            end
          end
        end
        MODE_QUERY: begin
          b = earliest(armed);
          if (b < 0) push(0, ST_NONE, 32'hFFFF_FFFF, 1);
          else push(b[3:0], ST_OK,
                    q.now_ms < deadline[b] ? deadline[b] - q.now_ms : 32'd0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_t         in_req = '0;
  logic        out_valid;
  out_t        out_res;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  timer_scoreboard sb = new();
  int   idle_pct = 0;
  int   cycles = 0;
  logic [31:0] clock_ms = 1000;

  always #2 clk = ~clk;

  deadline_timer_table_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // results cannot be stalled: check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  // watchdog on a generous cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // send one request; it is taken at the edge where start is high and busy low
  task automatic send_request(in_t q);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(q);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SLOTS_DEF * 20) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_window(logic [31:0] v);
    drain();
    psel <= 1;
    pwrite <= 1;
    paddr <= 0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.window = v;
    @(posedge clk);
  endtask

  task automatic cmd(logic [2:0] m, logic [3:0] s, logic [31:0] p, bit r, bit f,
                     logic [31:0] t);
    in_t q;
    q.mode = m;
    q.slot = s;
    q.period_ms = p;
    q.repeat_mode = r;
    q.from_now = f;
    q.now_ms = t;
    send_request(q);
  endtask

  // mostly plausible timer traffic with a forward-moving clock, some noise
  task automatic random_request();
    int pick;
    logic [31:0] p;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(40);
    p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
    if (pick < 3) clock_ms = $urandom;
    if (pick < 30)
      cmd(MODE_ADD, 4'($urandom), p, 1'($urandom), 1'($urandom), clock_ms);
    else if (pick < 40)
      cmd(MODE_CANCEL, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), clock_ms);
    else if (pick < 50)
      cmd(MODE_REFRESH, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), clock_ms);
    else if (pick < 62)
      cmd(MODE_RESET, 4'($urandom), p, 1'($urandom), 1'($urandom), clock_ms);
    else if (pick < 85)
      cmd(MODE_COLLECT, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), clock_ms);
    else if (pick < 97)
      cmd(MODE_QUERY, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), clock_ms);
    else
      cmd(3'(6 + $urandom_range(1)), 4'($urandom), $urandom, 1'($urandom),
          1'($urandom), $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, fill to full, each command, extremes
    cmd(MODE_COLLECT, 0, 0, 0, 0, 0);
    cmd(MODE_QUERY, 0, 0, 0, 0, 0);
    cmd(MODE_CANCEL, 4'hF, 0, 0, 0, 0);
    cmd(MODE_RESET, 3, 0, 0, 0, 5);
    cmd(MODE_RESET, 3, 7, 0, 1, 5);
    for (int i = 0; i < 16; i++) cmd(MODE_ADD, 0, i * 3, i[0], 0, 100);
    cmd(MODE_ADD, 0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    cmd(MODE_QUERY, 0, 0, 0, 0, 101);
    cmd(MODE_REFRESH, 2, 0, 0, 0, 50);
    cmd(MODE_RESET, 4, 32'hFFFF_FFFF, 0, 0, 120);
    cmd(MODE_RESET, 5, 9, 0, 1, 120);
    cmd(MODE_COLLECT, 0, 0, 0, 0, 130);
    cmd(MODE_CANCEL, 1, 0, 0, 0, 130);
    cmd(3'd7, 4'hF, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    // clock jumps far ahead, then back far: everything expires
    cmd(MODE_COLLECT, 0, 0, 0, 0, 32'hFFFF_FFF0);
    cmd(MODE_COLLECT, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  write_window(32'd0); end
        1: begin idle_pct = 71; write_window(32'hFFFF_FFFF); end
        2: begin idle_pct = 0;  write_window(32'd100); end
        default: begin idle_pct = 17; write_window($urandom); end
      endcase
      for (int n = 0; n < 18; n++) random_request();
    end

    drain();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> sim.f
design/dtt_pkg.sv
design/dtt_front.sv
design/dtt_fifo.sv
design/dtt_back.sv
design/deadline_timer_table_unit.sv
sim/testbench.sv
